// ===== src/safs_pkg.sv =====
// Shared constants and types for the slot allocator with a free stack.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package safs_pkg;

  localparam int SLOTS_DEF = 64;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int REQ_W = 2;
  localparam int IDX_W = 6;
  localparam int WORD_W = 32;
  localparam int STAT_W = 2;

  localparam logic [REQ_W-1:0] REQ_ADD = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_GET = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD = 2'd2;

  typedef struct packed {
    logic load;
    logic lookup;
    logic commit;
  } safs_cmd_t;

endpackage

// ===== src/safs_ctrl.sv =====
// Request sequencer for the slot allocator: handshakes and step commands.
// Depends on safs_pkg for the command struct.
`timescale 1ns / 1ps

module safs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output safs_pkg::safs_cmd_t cmd
);
  import safs_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    LOOKUP,
    FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_comb begin
    in_ready = (state == IDLE);
    cmd.load = in_valid && (state == IDLE);
    cmd.lookup = (state == LOOKUP);
    cmd.commit = (state == FINISH) && (!out_valid || out_ready);
    state_next = state;
    out_valid_next = out_valid && !out_ready;
    case (state)
      IDLE: begin
        if (in_valid) begin
          state_next = LOOKUP;
        end
      end
      LOOKUP: begin
        state_next = FINISH;
      end
      FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = IDLE;
          out_valid_next = 1'b1;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== src/safs_datapath.sv =====
// Slot store, free stack, counters and result register of the allocator.
// Depends on safs_pkg for field widths, codes and the command struct.
`timescale 1ns / 1ps

module safs_datapath #(
  parameter int SLOTS = safs_pkg::SLOTS_DEF,
  parameter int DATA_WIDTH = safs_pkg::DATA_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  safs_pkg::safs_cmd_t         cmd,
  input  logic [safs_pkg::REQ_W-1:0]  req_type,
  input  logic [safs_pkg::IDX_W-1:0]  slot_index,
  input  logic                        write_data,
  input  logic [safs_pkg::WORD_W-1:0] data_word,
  output logic [safs_pkg::IDX_W-1:0]  slot_out,
  output logic [safs_pkg::WORD_W-1:0] read_word,
  output logic [safs_pkg::STAT_W-1:0] status
);
  import safs_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int KW = (CW > IDX_W) ? CW : IDX_W;

  logic [DATA_WIDTH-1:0] slot_store [SLOTS];
  logic [SW-1:0]         free_stack [SLOTS];
  logic [CW-1:0]         free_count;
  logic [CW-1:0]         high_water;

  logic [REQ_W-1:0]      req_q;
  logic [IDX_W-1:0]      idx_q;
  logic                  wr_q;
  logic [DATA_WIDTH-1:0] word_q;
  logic [SW-1:0]         stack_q;
  logic [DATA_WIDTH-1:0] store_q;

  logic [CW-1:0]         fc_dec;
  logic [KW-1:0]         idx_k;
  logic                  idx_ok;
  logic                  pop;
  logic                  push;
  logic                  grow;
  logic                  store_we;
  logic [SW-1:0]         store_addr;
  logic [DATA_WIDTH-1:0] store_wd;
  logic [IDX_W-1:0]      slot_res;
  logic [WORD_W-1:0]     word_res;
  logic [STAT_W-1:0]     stat_res;

  always_comb begin
    fc_dec = free_count - CW'(1);
    idx_k = KW'(idx_q);
    idx_ok = (idx_k < KW'(high_water)) && (idx_k < KW'(SLOTS));
    pop = 1'b0;
    push = 1'b0;
    grow = 1'b0;
    store_we = 1'b0;
    store_addr = stack_q;
    store_wd = word_q;
    slot_res = idx_q;
    word_res = '0;
    stat_res = STAT_OK;
    case (req_q)
      REQ_ADD: begin
        if (free_count != '0) begin
          pop = 1'b1;
          store_we = wr_q;
          slot_res = IDX_W'(stack_q);
        end else if (high_water < CW'(SLOTS)) begin
          // A fresh slot is cleared when no word comes with it.
          grow = 1'b1;
          store_we = 1'b1;
          store_addr = high_water[SW-1:0];
          store_wd = wr_q ? word_q : '0;
          slot_res = IDX_W'(high_water[SW-1:0]);
        end else begin
          slot_res = '0;
          stat_res = STAT_FULL;
        end
      end
      REQ_REMOVE: begin
        if (idx_ok && (free_count < CW'(SLOTS))) begin
          push = 1'b1;
        end else begin
          stat_res = STAT_BAD;
        end
      end
      REQ_GET: begin
        if (idx_ok) begin
          word_res = WORD_W'(store_q);
        end else begin
          stat_res = STAT_BAD;
        end
      end
      default: begin
        slot_res = '0;
        stat_res = STAT_BAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req_type;
      idx_q <= slot_index;
      wr_q <= write_data;
      word_q <= DATA_WIDTH'(data_word);
    end
    if (cmd.lookup) begin
      stack_q <= free_stack[fc_dec[SW-1:0]];
      store_q <= slot_store[SW'(idx_q)];
    end
    if (cmd.commit && store_we) begin
      slot_store[store_addr] <= store_wd;
    end
    if (cmd.commit && push) begin
      free_stack[free_count[SW-1:0]] <= SW'(idx_q);
    end
    if (cmd.commit) begin
      slot_out <= slot_res;
      read_word <= word_res;
      status <= stat_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_count <= '0;
      high_water <= '0;
    end else if (cmd.commit) begin
      if (pop) begin
        free_count <= fc_dec;
      end else if (push) begin
        free_count <= free_count + CW'(1);
      end
      if (grow) begin
        high_water <= high_water + CW'(1);
      end
    end
  end

endmodule

// ===== src/slot_allocator_free_stack.sv =====
// Top level of the slot allocator with LIFO reuse of freed slots.
// Instantiates safs_ctrl and safs_datapath; depends on safs_pkg.
`timescale 1ns / 1ps
//
//   channel   | handshake           | words
//   request   | in_valid, in_ready  | req_type, slot_index, write_data, data_word
//   result    | out_valid, out_ready| slot_out, read_word, status
//
// A request passes through accept, a registered read of the free stack top
// and the addressed slot, then the update and the result register load.
// One request is in work at a time: a new word waits until the last one is through.
// A new request may be accepted while the last result waits; it then holds
// in its final step until the result register is free.
// Synchronous reset empties the free stack and clears the high-water mark.

module slot_allocator_free_stack #(
  parameter int SLOTS = safs_pkg::SLOTS_DEF,
  parameter int DATA_WIDTH = safs_pkg::DATA_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [safs_pkg::REQ_W-1:0]  req_type,
  input  logic [safs_pkg::IDX_W-1:0]  slot_index,
  input  logic                        write_data,
  input  logic [safs_pkg::WORD_W-1:0] data_word,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [safs_pkg::IDX_W-1:0]  slot_out,
  output logic [safs_pkg::WORD_W-1:0] read_word,
  output logic [safs_pkg::STAT_W-1:0] status
);
  import safs_pkg::*;

  safs_cmd_t cmd;

  safs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  safs_datapath #(
    .SLOTS      (SLOTS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .req_type   (req_type),
    .slot_index (slot_index),
    .write_data (write_data),
    .data_word  (data_word),
    .slot_out   (slot_out),
    .read_word  (read_word),
    .status     (status)
  );

endmodule

// ===== src/safs_checker.sv =====
// Port-level checks for the slot allocator, bound to the top level.
// Depends on safs_pkg for the status codes.
`timescale 1ns / 1ps

module safs_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [safs_pkg::REQ_W-1:0]  req_type,
  input logic [safs_pkg::IDX_W-1:0]  slot_index,
  input logic                        write_data,
  input logic [safs_pkg::WORD_W-1:0] data_word,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [safs_pkg::IDX_W-1:0]  slot_out,
  input logic [safs_pkg::WORD_W-1:0] read_word,
  input logic [safs_pkg::STAT_W-1:0] status
);
  import safs_pkg::*;

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(slot_out) && $stable(read_word)
      && $stable(status))
    else $error("result changed while stalled");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("request accepted while another is in work");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_FULL |-> slot_out == '0 && read_word == '0)
    else $error("full result carries a slot or word");

  a_word_only_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_word != '0 |-> status == STAT_OK)
    else $error("word returned with an error status");

endmodule

bind slot_allocator_free_stack safs_checker u_safs_checker (.*);

// ===== sim/slot_allocator_free_stack_tb.sv =====
// Self-checking testbench for slot_allocator_free_stack: directed and random requests,
// with random idle bursts on both channels. Results are checked against a built-in predictor.
// Depends on safs_pkg and the slot_allocator_free_stack RTL.
`timescale 1ns / 1ps

module slot_allocator_free_stack_tb;
  import safs_pkg::*;

  localparam int NSLOTS = 64;
  localparam int RANDOM_WORDS = 700;
  localparam int QUIET_TAIL = 100;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  typedef struct {
    logic [REQ_W-1:0]  req;
    logic [IDX_W-1:0]  idx;
    logic              wr;
    logic [WORD_W-1:0] word;
  } request_t;

  typedef struct {
    logic [IDX_W-1:0]  slot;
    logic [WORD_W-1:0] word;
    logic [STAT_W-1:0] stat;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [REQ_W-1:0] req_type = '0;
  logic [IDX_W-1:0] slot_index = '0;
  logic write_data = 1'b0;
  logic [WORD_W-1:0] data_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [IDX_W-1:0] slot_out;
  logic [WORD_W-1:0] read_word;
  logic [STAT_W-1:0] status;

  request_t pending_words[$];
  reply_t expected_replies[$];
  int errors = 0;
  int cycles = 0;
  int send_gap = 0;
  int recv_stall = 0;

  logic [WORD_W-1:0] mdl_store[NSLOTS];
  logic [IDX_W-1:0] mdl_free[NSLOTS];
  int mdl_free_cnt = 0;
  int mdl_hw = 0;

  slot_allocator_free_stack uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .slot_index(slot_index),
    .write_data(write_data), .data_word(data_word),
    .out_valid(out_valid), .out_ready(out_ready),
    .slot_out(slot_out), .read_word(read_word), .status(status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic reply_t predict_reply(request_t r);
    reply_t p;
    int slot;
    p.slot = '0;
    p.word = '0;
    p.stat = STAT_BAD;
    if (r.req == REQ_ADD) begin
      slot = -1;
      if (mdl_free_cnt > 0) begin
        mdl_free_cnt--;
        slot = int'(mdl_free[mdl_free_cnt[IDX_W-1:0]]);
      end else if (mdl_hw < NSLOTS) begin
        slot = mdl_hw;
        mdl_hw++;
      end
      if (slot < 0) begin
        p.stat = STAT_FULL;
      end else begin
        if (r.wr) begin
          mdl_store[slot[IDX_W-1:0]] = r.word;
        end
        p.slot = slot[IDX_W-1:0];
        p.stat = STAT_OK;
      end
    end else if (r.req == REQ_REMOVE) begin
      p.slot = r.idx;
      if (int'(r.idx) < mdl_hw && mdl_free_cnt < NSLOTS) begin
        mdl_free[mdl_free_cnt[IDX_W-1:0]] = r.idx;
        mdl_free_cnt++;
        p.stat = STAT_OK;
      end
    end else if (r.req == REQ_GET) begin
      p.slot = r.idx;
      if (int'(r.idx) < mdl_hw) begin
        p.word = mdl_store[r.idx];
        p.stat = STAT_OK;
      end
    end
    return p;
  endfunction

  function automatic request_t make_request(logic [REQ_W-1:0] req, logic [IDX_W-1:0] idx,
                                            logic wr, logic [WORD_W-1:0] word);
    request_t r;
    r.req = req;
    r.idx = idx;
    r.wr = wr;
    r.word = word;
    return r;
  endfunction

  function automatic request_t random_request(int add_pct, int remove_pct, int get_pct);
    request_t r;
    int pick;
    int w;
    pick = $urandom_range(0, 99);
    if (pick < add_pct) begin
      r.req = REQ_ADD;
    end else if (pick < add_pct + remove_pct) begin
      r.req = REQ_REMOVE;
    end else if (pick < add_pct + remove_pct + get_pct) begin
      r.req = REQ_GET;
    end else begin
      r.req = REQ_UNKNOWN;
    end
    r.idx = IDX_W'($urandom_range(0, NSLOTS - 1));
    r.wr = $urandom_range(0, 3) != 0;
    w = $urandom_range(0, 15);
    if (w == 0) begin
      r.word = '0;
    end else if (w == 1) begin
      r.word = '1;
    end else begin
      r.word = $urandom;
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [WORD_W-1:0] exp_v, logic [WORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // Driver: presents queued words and predicts each one as it is accepted.
  always @(posedge clk) begin
    reply_t p;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        p = predict_reply(make_request(req_type, slot_index, write_data, data_word));
        expected_replies.push_back(p);
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          req_type <= pending_words[0].req;
          slot_index <= pending_words[0].idx;
          write_data <= pending_words[0].wr;
          data_word <= pending_words[0].word;
          pending_words.pop_front();
          in_valid <= 1'b1;
          if (pending_words.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
            send_gap <= $urandom_range(1, 11);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction.
  always @(posedge clk) begin
    reply_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual slot %h word %h status %h",
                   $time, slot_out, read_word, status);
        end else begin
          e = expected_replies.pop_front();
          check_field("slot_out", WORD_W'(e.slot), WORD_W'(slot_out));
          check_field("read_word", e.word, read_word);
          check_field("status", WORD_W'(e.stat), WORD_W'(status));
        end
      end
      if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (pending_words.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
          recv_stall <= $urandom_range(1, 11);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NSLOTS; i++) begin
      mdl_store[i] = '0;
      mdl_free[i] = '0;
    end

    pending_words.push_back(make_request(REQ_GET, 6'd0, 1'b0, 32'h0));
    pending_words.push_back(make_request(REQ_REMOVE, 6'd0, 1'b0, 32'h0));
    pending_words.push_back(make_request(REQ_UNKNOWN, 6'd63, 1'b1, 32'hFFFF_FFFF));
    pending_words.push_back(make_request(REQ_ADD, 6'd63, 1'b1, 32'hFFFF_FFFF));
    pending_words.push_back(make_request(REQ_ADD, 6'd0, 1'b1, 32'h0000_0000));
    pending_words.push_back(make_request(REQ_ADD, 6'd0, 1'b0, 32'h1234_5678));
    pending_words.push_back(make_request(REQ_GET, 6'd0, 1'b0, 32'h0));
    pending_words.push_back(make_request(REQ_GET, 6'd1, 1'b0, 32'h0));
    pending_words.push_back(make_request(REQ_GET, 6'd2, 1'b0, 32'h0));
    pending_words.push_back(make_request(REQ_GET, 6'd3, 1'b0, 32'h0));
    pending_words.push_back(make_request(REQ_GET, 6'd63, 1'b1, 32'hFFFF_FFFF));
    pending_words.push_back(make_request(REQ_REMOVE, 6'd1, 1'b0, 32'h0));
    pending_words.push_back(make_request(REQ_REMOVE, 6'd1, 1'b0, 32'h0));
    pending_words.push_back(make_request(REQ_ADD, 6'd5, 1'b1, 32'hA5A5_A5A5));
    pending_words.push_back(make_request(REQ_ADD, 6'd5, 1'b0, 32'h5A5A_5A5A));
    pending_words.push_back(make_request(REQ_GET, 6'd1, 1'b0, 32'h0));
    pending_words.push_back(make_request(REQ_REMOVE, 6'd63, 1'b0, 32'h0));
    pending_words.push_back(make_request(REQ_REMOVE, 6'd3, 1'b0, 32'h0));

    // Fill past capacity, then drain until the free stack fills and refuses removes, then mix.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i < 160) begin
        pending_words.push_back(random_request(70, 10, 17));
      end else if (i < 340) begin
        pending_words.push_back(random_request(10, 70, 17));
      end else begin
        pending_words.push_back(random_request(35, 30, 32));
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() > 0 || in_valid || expected_replies.size() > 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/safs_pkg.sv
src/safs_ctrl.sv
src/safs_datapath.sv
src/slot_allocator_free_stack.sv
src/safs_checker.sv
sim/slot_allocator_free_stack_tb.sv
